// ===== design/plob_pkg.sv =====
// ----------------------------------------------------------------------------
// plob_pkg
// Shared types and constants for the price level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int LEVELS     = 32;
  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 32;
  localparam int IDX_BITS   = $clog2(LEVELS);
  localparam int CNT_BITS   = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_PLACE  = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_FILL   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_SHORT   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // classified command passed from front to back
  typedef struct packed {
    logic                  nop;     // zero quantity
    logic                  is_add;  // load or place; else cancel or fill
    logic                  bid;     // target side
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } cmd_t;

  typedef struct packed {
    status_t               status;
    logic                  bid_present;
    logic [PRICE_BITS-1:0] bid_price;
    logic [QTY_BITS-1:0]   bid_qty;
    logic                  ask_present;
    logic [PRICE_BITS-1:0] ask_price;
    logic [QTY_BITS-1:0]   ask_qty;
    logic [PRICE_BITS-1:0] mid;
  } res_t;

endpackage

// ===== design/plob_front.sv =====
// ----------------------------------------------------------------------------
// plob_front
// Takes input items and classifies them into side and operation commands.
// Place and cancel pick the side against the mid of the previous item, so
// only one item is in flight between the front and the result.
// ----------------------------------------------------------------------------
module plob_front import plob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_func,
  input  logic                  in_is_buy,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic [QTY_BITS-1:0]   in_quantity,
  input  logic [PRICE_BITS-1:0] mid,
  input  logic                  done,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic busy_r, busy_nxt;
  logic vld_r, vld_nxt;
  cmd_t cmd_r, cmd_nxt;
  func_t f;

  assign in_full   = busy_r;
  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;
  assign f         = func_t'(in_func);

  always_comb begin
    busy_nxt = busy_r;
    vld_nxt  = vld_r;
    cmd_nxt  = cmd_r;
    if (vld_r && cmd_ready) vld_nxt = 1'b0;
    if (done) busy_nxt = 1'b0;
    if (in_push && !busy_r) begin
      busy_nxt       = 1'b1;
      vld_nxt        = 1'b1;
      cmd_nxt.nop    = (in_quantity == '0);
      cmd_nxt.is_add = (f == FUNC_LOAD) || (f == FUNC_PLACE);
      cmd_nxt.bid    = ((f == FUNC_LOAD) || (f == FUNC_FILL)) ? in_is_buy
                                                              : !(in_price > mid);
      cmd_nxt.price  = in_price;
      cmd_nxt.qty    = in_quantity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

`ifndef SYNTHESIS
  a_vld_busy: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> busy_r) else $error("command without busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !done |=> busy_r) else $error("busy dropped");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !busy_r |=> vld_r) else $error("accept lost");
`endif

endmodule

// ===== design/plob_side.sv =====
// ----------------------------------------------------------------------------
// plob_side
// One sorted side as a chain of level cells. All cells compare against the
// command price at once; an insert shifts the tail one cell down.
// ----------------------------------------------------------------------------
module plob_side import plob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  is_bid,
  input  logic                  go,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  present,
  output logic [PRICE_BITS-1:0] best_price,
  output logic [QTY_BITS-1:0]   best_qty
);

  logic [PRICE_BITS-1:0] pr_r [LEVELS];
  logic [QTY_BITS-1:0]   qt_r [LEVELS];
  logic [CNT_BITS-1:0]   cnt_r;
  logic [LEVELS-1:0]     used, ahead, match;
  logic [QTY_BITS:0]     sum;
  logic [QTY_BITS-1:0]   sat;
  logic                  hit, full;
  logic [IDX_BITS-1:0]   hit_idx, slot;
  logic [QTY_BITS-1:0]   hit_qty;
  logic                  do_add, do_ins, do_sub;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      used[i]  = (CNT_BITS'(i) < cnt_r);
      ahead[i] = used[i] && (is_bid ? (pr_r[i] > cmd.price) : (pr_r[i] < cmd.price));
      match[i] = used[i] && (pr_r[i] == cmd.price);
    end
  end

  // levels are unique, so at most one match; slot is count of levels ahead
  always_comb begin
    hit     = |match;
    hit_idx = '0;
    hit_qty = '0;
    slot    = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (match[i]) begin
        hit_idx = IDX_BITS'(i);
        hit_qty = qt_r[i];
      end
      if (ahead[i]) slot = IDX_BITS'(i + 1);
    end
  end

  assign full = (cnt_r == CNT_BITS'(LEVELS));
  assign sum  = {1'b0, hit_qty} + {1'b0, cmd.qty};
  assign sat  = sum[QTY_BITS] ? '1 : sum[QTY_BITS-1:0];

  always_comb begin
    status = ST_OK;
    do_add = 1'b0;
    do_ins = 1'b0;
    do_sub = 1'b0;
    if (!cmd.nop) begin
      if (cmd.is_add) begin
        if (hit) do_add = 1'b1;
        else if (full) status = ST_FULL;
        else do_ins = 1'b1;
      end else begin
        if (!hit) status = ST_MISSING;
        else if (hit_qty < cmd.qty) status = ST_SHORT;
        else do_sub = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go && do_ins) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (go) begin
      for (int i = 0; i < LEVELS; i++) begin
        if (do_ins) begin
          if (IDX_BITS'(i) == slot) begin
            pr_r[i] <= cmd.price;
            qt_r[i] <= cmd.qty;
          end else if (IDX_BITS'(i) > slot && i > 0) begin
            pr_r[i] <= pr_r[(i > 0) ? i - 1 : 0];
            qt_r[i] <= qt_r[(i > 0) ? i - 1 : 0];
          end
        end else if ((do_add || do_sub) && IDX_BITS'(i) == hit_idx) begin
          qt_r[i] <= do_add ? sat : (hit_qty - cmd.qty);
        end
      end
    end
  end

  // best level: first used entry with nonzero quantity
  always_comb begin
    present    = 1'b0;
    best_price = '0;
    best_qty   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (used[i] && qt_r[i] != '0) begin
        present    = 1'b1;
        best_price = pr_r[i];
        best_qty   = qt_r[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(LEVELS)) else $error("count overflow");
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match)) else $error("duplicate level");
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    go && do_ins |=> cnt_r == $past(cnt_r) + 1'b1) else $error("insert lost");
`endif

endmodule

// ===== design/plob_back.sv =====
// ----------------------------------------------------------------------------
// plob_back
// Executes a command on one side (state S_EXEC), then registers best levels and
// mid into the result register (state S_BEST).
// ----------------------------------------------------------------------------
module plob_back import plob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  res_valid,
  input  logic                  res_taken,
  output res_t                  res,
  output logic [PRICE_BITS-1:0] mid
);

  typedef enum logic [1:0] {S_EXEC, S_BEST, S_HOLD} state_t;
  state_t state_r;
  logic go;
  status_t st_b, st_a, st_r;
  logic bp, ap;
  logic [PRICE_BITS-1:0] bpr, apr, mid_r, mid_calc;
  logic [QTY_BITS-1:0] bq, aq;
  res_t res_r;

  assign cmd_ready = (state_r == S_EXEC);
  assign go        = cmd_valid && cmd_ready;
  assign res_valid = (state_r == S_HOLD);
  assign res       = res_r;
  assign mid       = mid_r;
  assign mid_calc  = (bpr >> 1) + (apr >> 1) + PRICE_BITS'(bpr[0] & apr[0]);

  plob_side u_bid (.clk, .rst_n, .is_bid(1'b1), .go(go && cmd.bid), .cmd,
    .status(st_b), .present(bp), .best_price(bpr), .best_qty(bq));
  plob_side u_ask (.clk, .rst_n, .is_bid(1'b0), .go(go && !cmd.bid), .cmd,
    .status(st_a), .present(ap), .best_price(apr), .best_qty(aq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EXEC;
      mid_r   <= '0;
    end else begin
      case (state_r)
        S_EXEC: if (go) begin
          st_r    <= cmd.bid ? st_b : st_a;
          state_r <= S_BEST;
        end
        S_BEST: begin
          res_r.status      <= st_r;
          res_r.bid_present <= bp;
          res_r.bid_price   <= bpr;
          res_r.bid_qty     <= bq;
          res_r.ask_present <= ap;
          res_r.ask_price   <= apr;
          res_r.ask_qty     <= aq;
          res_r.mid         <= (bp && ap) ? mid_calc : mid_r;
          if (bp && ap) mid_r <= mid_calc;
          state_r <= S_HOLD;
        end
        S_HOLD: if (res_taken) state_r <= S_EXEC;
        default: state_r <= S_EXEC;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_best_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BEST |=> state_r == S_HOLD) else $error("sequence broken");
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> res_r.mid == mid_r) else $error("mid mismatch");
  a_exec_go: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> state_r == S_BEST) else $error("command dropped");
`endif

endmodule

// ===== design/price_level_order_book_unit.sv =====
// ----------------------------------------------------------------------------
// price_level_order_book_unit
// Level-2 order book with sorted bid and ask level tables.
// ----------------------------------------------------------------------------
// Input channel: push/full with in_func, in_is_buy, in_price, in_quantity.
// Result channel: empty/pop; one result per item with status, best bid,
// best ask and mid price.
// On acceptance the front command register is loaded; the back then runs
// the level cell chain (compare all levels, shift on insert) in S_EXEC and
// registers the best levels in S_BEST, after which the result shows. The
// next item is accepted the cycle after its predecessor's result is popped,
// because place and cancel choose a side from the mid that this result
// leaves behind.
// While the receiver does not pop, the result holds and full stays high.
// Reset empties both sides and clears the mid to zero.
// ----------------------------------------------------------------------------
module price_level_order_book_unit import plob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            in_func,
  input  logic                  in_is_buy,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic [QTY_BITS-1:0]   in_quantity,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            out_status,
  output logic                  out_bid_present,
  output logic [PRICE_BITS-1:0] out_best_bid_price,
  output logic [QTY_BITS-1:0]   out_best_bid_qty,
  output logic                  out_ask_present,
  output logic [PRICE_BITS-1:0] out_best_ask_price,
  output logic [QTY_BITS-1:0]   out_best_ask_qty,
  output logic [PRICE_BITS-1:0] out_mid_price
);

  logic cmd_valid, cmd_ready, res_valid, taken;
  cmd_t cmd;
  res_t res;
  logic [PRICE_BITS-1:0] mid;

  assign empty = !res_valid;
  assign taken = pop && res_valid;

  plob_front u_front (.clk, .rst_n, .in_push(push), .in_full(full), .in_func,
    .in_is_buy, .in_price, .in_quantity, .mid, .done(taken),
    .cmd_valid, .cmd_ready, .cmd);

  plob_back u_back (.clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .res_valid, .res_taken(taken), .res, .mid);

  assign out_status         = res.status;
  assign out_bid_present    = res.bid_present;
  assign out_best_bid_price = res.bid_price;
  assign out_best_bid_qty   = res.bid_qty;
  assign out_ask_present    = res.ask_present;
  assign out_best_ask_price = res.ask_price;
  assign out_best_ask_qty   = res.ask_qty;
  assign out_mid_price      = res.mid;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the price level order book against an in-bench book predictor.
// A short directed table runs first, then random load/place/cancel/fill
// traffic, with random idle cycles on push and pop.
// ----------------------------------------------------------------------------
module tb_top;
  import plob_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM  = 1100;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] QMAX = 32'hFFFF_FFFF;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [1:0]            in_func;
  logic                  in_is_buy;
  logic [PRICE_BITS-1:0] in_price;
  logic [QTY_BITS-1:0]   in_quantity;
  logic                  empty;
  logic                  pop;
  res_t                  got;

  price_level_order_book_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_func            (in_func),
    .in_is_buy          (in_is_buy),
    .in_price           (in_price),
    .in_quantity        (in_quantity),
    .empty              (empty),
    .pop                (pop),
    .out_status         (got.status),
    .out_bid_present    (got.bid_present),
    .out_best_bid_price (got.bid_price),
    .out_best_bid_qty   (got.bid_qty),
    .out_ask_present    (got.ask_present),
    .out_best_ask_price (got.ask_price),
    .out_best_ask_qty   (got.ask_qty),
    .out_mid_price      (got.mid)
  );

  // book copy: index 1 = bids (descending), 0 = asks (ascending)
  logic [31:0] lvl_price [2][LEVELS];
  logic [31:0] lvl_qty   [2][LEVELS];
  int          lvl_cnt   [2];
  logic [31:0] book_mid;

  res_t        pending_quotes[$];
  int          mismatches;
  int          cycles;
  bit          row_typed;
  res_t        row_quote;
  bit          calm;

  typedef struct {
    func_t       f;
    bit          b;
    logic [31:0] p;
    logic [31:0] q;
    bit          typed;
    res_t        e;
  } row_t;
  row_t rows[$];

  function automatic void add_row(func_t f, bit b, logic [31:0] p, logic [31:0] q,
                                  bit typed, res_t e);
    row_t r;
    r.f = f; r.b = b; r.p = p; r.q = q; r.typed = typed; r.e = e;
    rows.insert(rows.size(), r);
  endfunction

  function automatic res_t quote(status_t st, bit bpr, logic [31:0] bp, logic [31:0] bq,
                                 bit apr, logic [31:0] ap, logic [31:0] aq,
                                 logic [31:0] m);
    res_t r;
    r.status = st; r.bid_present = bpr; r.bid_price = bp; r.bid_qty = bq;
    r.ask_present = apr; r.ask_price = ap; r.ask_qty = aq; r.mid = m;
    return r;
  endfunction

  function automatic res_t apply_event(func_t f, bit b, logic [31:0] p, logic [31:0] q);
    res_t    r;
    status_t st;
    int      s, i, j;
    bit      found;
    st = ST_OK;
    if (q != 0) begin
      s = (f == FUNC_LOAD || f == FUNC_FILL) ? int'(b) : int'(!(p > book_mid));
      i = 0;
      while (i < lvl_cnt[s] && (s == 1 ? lvl_price[s][i] > p : lvl_price[s][i] < p))
        i++;
      found = (i < lvl_cnt[s]) && (lvl_price[s][i] == p);
      if (f == FUNC_LOAD || f == FUNC_PLACE) begin
        if (found) begin
          lvl_qty[s][i] = (q > QMAX - lvl_qty[s][i]) ? QMAX : lvl_qty[s][i] + q;
        end else if (lvl_cnt[s] >= LEVELS) begin
          st = ST_FULL;
        end else begin
          for (j = lvl_cnt[s]; j > i; j--) begin
            lvl_price[s][j] = lvl_price[s][j-1];
            lvl_qty[s][j]   = lvl_qty[s][j-1];
          end
          lvl_price[s][i] = p;
          lvl_qty[s][i]   = q;
          lvl_cnt[s]++;
        end
      end else if (!found) begin
        st = ST_MISSING;
      end else if (lvl_qty[s][i] < q) begin
        st = ST_SHORT;
      end else begin
        lvl_qty[s][i] -= q;
      end
    end
    r = quote(st, 0, 0, 0, 0, 0, 0, 0);
    for (i = 0; i < lvl_cnt[1]; i++)
      if (!r.bid_present && lvl_qty[1][i] != 0) begin
        r.bid_present = 1; r.bid_price = lvl_price[1][i]; r.bid_qty = lvl_qty[1][i];
      end
    for (i = 0; i < lvl_cnt[0]; i++)
      if (!r.ask_present && lvl_qty[0][i] != 0) begin
        r.ask_present = 1; r.ask_price = lvl_price[0][i]; r.ask_qty = lvl_qty[0][i];
      end
    if (r.bid_present && r.ask_present)
      book_mid = (r.bid_price >> 1) + (r.ask_price >> 1) + (r.bid_price & r.ask_price & 1);
    r.mid = book_mid;
    return r;
  endfunction

  // random event, mostly aimed at prices that exist in the book
  task automatic pick_event(output func_t f, output bit b, output logic [31:0] p,
                            output logic [31:0] q);
    int r, s, k;
    r = $urandom_range(0, 99);
    b = $urandom_range(0, 1);
    q = $urandom_range(1, 1000);
    if (r < 10) begin
      f = func_t'($urandom_range(0, 3));
      p = $urandom;
      q = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
    end else if (r < 32) begin
      f = FUNC_LOAD;
      p = b ? 32'd1000 - $urandom_range(0, 45) : 32'd1000 + $urandom_range(1, 45);
      if ($urandom_range(0, 19) == 0) q = QMAX - $urandom_range(0, 3);
    end else if (r < 50) begin
      f = FUNC_PLACE;
      k = $urandom_range(0, 45);
      p = (b && book_mid >= k) ? book_mid - k : book_mid + k;
    end else begin
      f = (r < 72) ? FUNC_CANCEL : FUNC_FILL;
      s = b;
      if (lvl_cnt[s] == 0) s = !s;
      b = s;
      if (lvl_cnt[s] == 0) begin
        p = 32'd1000;
      end else begin
        k = $urandom_range(0, lvl_cnt[s] - 1);
        p = lvl_price[s][k];
        case ($urandom_range(0, 9))
          0:       q = lvl_qty[s][k] + 1;
          1:       q = lvl_qty[s][k];
          2:       q = 0;
          default: q = (lvl_qty[s][k] > 1) ? $urandom_range(1, lvl_qty[s][k]) : 1;
        endcase
        if (q == 0 && lvl_qty[s][k] == QMAX) q = 1;
      end
    end
  endtask

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // prediction at each input transfer
  always @(posedge clk) begin
    res_t e;
    if (rst_n && push && !full) begin
      e = apply_event(func_t'(in_func), in_is_buy, in_price, in_quantity);
      pending_quotes.insert(pending_quotes.size(), row_typed ? row_quote : e);
    end
  end

  // check at each result transfer
  always @(posedge clk) begin
    res_t e;
    bit   bad;
    if (rst_n && pop && !empty) begin
      if (pending_quotes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        e = pending_quotes.pop_front();
        bad = (got.status !== e.status) || (got.bid_present !== e.bid_present) ||
              (got.bid_price !== e.bid_price) || (got.bid_qty !== e.bid_qty) ||
              (got.ask_present !== e.ask_present) || (got.ask_price !== e.ask_price) ||
              (got.ask_qty !== e.ask_qty) || (got.mid !== e.mid);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", e, got);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(func_t f, bit b, logic [31:0] p, logic [31:0] q, bit typed,
                      res_t e);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 36) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1; in_func = f; in_is_buy = b; in_price = p; in_quantity = q;
    row_typed = typed; row_quote = e;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 1'b0;
  endtask

  initial begin
    func_t       f;
    bit          b;
    logic [31:0] p, q;
    res_t        none;
    none = quote(ST_OK, 0, 0, 0, 0, 0, 0, 0);
    push = 0; pop = 0; in_func = 0; in_is_buy = 0; in_price = 0; in_quantity = 0;
    rst_n = 0; row_typed = 0; row_quote = none; calm = 0;
    mismatches = 0; cycles = 0;
    lvl_cnt[0] = 0; lvl_cnt[1] = 0; book_mid = 0;

    add_row(FUNC_FILL,   1, 100, 5, 1, quote(ST_MISSING, 0, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_CANCEL, 0, 0, 1, 1, quote(ST_MISSING, 0, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_LOAD,   1, 0, 0, 1, none);
    add_row(FUNC_LOAD,   1, 100, 10, 1, quote(ST_OK, 1, 100, 10, 0, 0, 0, 0));
    add_row(FUNC_LOAD,   0, 200, QMAX, 1,
            quote(ST_OK, 1, 100, 10, 1, 200, QMAX, 150));
    // saturating add on the ask side
    add_row(FUNC_PLACE,  0, 200, 1, 1,
            quote(ST_OK, 1, 100, 10, 1, 200, QMAX, 150));
    add_row(FUNC_FILL,   1, 100, 11, 1,
            quote(ST_SHORT, 1, 100, 10, 1, 200, QMAX, 150));
    // whole level taken: bid gone, mid held
    add_row(FUNC_FILL,   1, 100, 10, 1,
            quote(ST_OK, 0, 0, 0, 1, 200, QMAX, 150));
    add_row(FUNC_PLACE,  1, 150, 3, 0, none);
    add_row(FUNC_LOAD,   1, QMAX, 1, 0, none);
    add_row(FUNC_LOAD,   0, 0, 7, 0, none);
    add_row(FUNC_FILL,   0, 0, 7, 0, none);
    add_row(FUNC_FILL,   0, 0, 1, 0, none);
    add_row(FUNC_LOAD,   0, QMAX, 1, 0, none);
    add_row(FUNC_CANCEL, 1, 150, 2, 0, none);
    add_row(FUNC_CANCEL, 0, 300, 2, 0, none);
    add_row(FUNC_PLACE,  0, 120, 0, 0, none);
    add_row(FUNC_FILL,   1, QMAX, 1, 0, none);
    add_row(FUNC_FILL,   0, 200, QMAX, 0, none);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (rows[i]) send(rows[i].f, rows[i].b, rows[i].p, rows[i].q, rows[i].typed,
                           rows[i].e);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 700) begin
        while (pending_quotes.size() != 0) @(posedge clk);
      end
      pick_event(f, b, p, q);
      send(f, b, p, q, 0, none);
    end
    calm = 0;
    while (pending_quotes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_quotes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/plob_pkg.sv
design/plob_front.sv
design/plob_side.sv
design/plob_back.sv
design/price_level_order_book_unit.sv
dv/tb_top.sv
